>>> rtl/core/bic_pkg.sv
// ============================================================================
// bic_pkg
// Shared types, constants and distance helpers for the border/interior
// pixel classifier.
// ============================================================================
package bic_pkg;

  // Default sizing, handed to the top level as parameter defaults
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_HIST_BINS  = 256;
  localparam int DEF_COUNT_BITS = 32;

  // Fixed field widths
  localparam int CHAN_W        = 8;
  localparam int PIXEL_W       = 3 * CHAN_W;
  localparam int BIN_W         = 8;
  localparam int IMAGE_WIDTH_W = 12;
  localparam int THRESHOLD_W   = 9;
  localparam int OUT_COUNT_W   = 32;
  localparam int SQ_W          = 2 * CHAN_W;
  localparam int DIST_W        = 18;   // holds 3 * 255^2 and 511^2
  localparam int NEIGHBORS     = 8;
  localparam int WIN_COLS      = 6;    // two stored columns of three rows

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [IMAGE_WIDTH_W-1:0] IMAGE_WIDTH_RST = IMAGE_WIDTH_W'(640);
  localparam logic [THRESHOLD_W-1:0]   THRESHOLD_RST   = THRESHOLD_W'(30);
  localparam logic [IMAGE_WIDTH_W-1:0] MIN_IMAGE_WIDTH = IMAGE_WIDTH_W'(3);

  typedef enum logic [0:0] {
    ACT_PUSH       = 1'b0,
    ACT_READ_CLEAR = 1'b1
  } action_t;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH        = 1'b0,
    REG_DISTANCE_THRESHOLD = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    action_t            action;
    logic               start_of_frame;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  red;
    logic [BIN_W-1:0]   bin_index;
  } request_t;

  typedef struct packed {
    logic                   centre_valid;
    logic                   is_border;
    logic [CHAN_W-1:0]      centre_blue;
    logic [CHAN_W-1:0]      centre_green;
    logic [CHAN_W-1:0]      centre_red;
    logic                   bin_valid;
    logic [OUT_COUNT_W-1:0] border_count;
    logic [OUT_COUNT_W-1:0] interior_count;
  } result_t;

  // Square of max(a - b, 0)
  function automatic logic [SQ_W-1:0] bic_sat_sq(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? (a - b) : '0;
    return {{CHAN_W{1'b0}}, d} * {{CHAN_W{1'b0}}, d};
  endfunction

  // Squared one-sided color distance from centre to a neighbor
  function automatic logic [DIST_W-1:0] bic_sq_dist(input pixel_t ctr,
                                                    input pixel_t nb);
    return DIST_W'(bic_sat_sq(ctr.blue, nb.blue))
         + DIST_W'(bic_sat_sq(ctr.green, nb.green))
         + DIST_W'(bic_sat_sq(ctr.red, nb.red));
  endfunction

endpackage

>>> rtl/core/border_interior_pixel_classifier_top.sv
// ============================================================================
// border_interior_pixel_classifier_top
// Raster-order 3x3 border/interior classifier with per-blue-bin histograms.
// ============================================================================
// Usage
//   request channel (request_valid / request_ready / request) carries one
//   request per cycle when ready: a pixel push (with start_of_frame on row 0,
//   column 0) or a read-and-clear of one histogram bin.
//   result channel (result_valid / result_ready / result) returns exactly one
//   result per request, in order. A push whose centre lies inside the frame
//   (row and column of the arriving pixel both at least 2) carries the
//   classified centre; other pushes return an all-zero result; a bin read
//   returns both counts before the clear.
//   A request passes through stage 1, stage 2 and the result register.
//   Throughput: one request per cycle while results are taken, sustained by
//   line stores and a histogram memory with one read and one write port each,
//   each read a stage before its write, forwarding a same-cycle write.
//   Reset clears positions, pipeline valids and the histogram valid bits, so
//   every bin reads zero right away; no clearing pass is needed. Line store
//   contents are undefined until written.
//   Receiver stall: the result register holds; the two stages behind it
//   keep filling, and request_ready drops once all of them are full.
//   Configuration: APB writes to image_width (0x0) and distance_threshold
//   (0x4), allowed only while no request is in flight.
// ============================================================================
module border_interior_pixel_classifier_top
  import bic_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int HIST_BINS  = DEF_HIST_BINS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  // request channel
  input  logic                  request_valid,
  output logic                  request_ready,
  input  request_t              request,
  // result channel
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Column index width and the width used for the clamped row length
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int EWR = $clog2(MAX_WIDTH + 1);
  localparam int EW  = (EWR > IMAGE_WIDTH_W) ? EWR : IMAGE_WIDTH_W;
  localparam int HBW = $clog2(HIST_BINS);
  localparam int HW  = 2 * COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [IMAGE_WIDTH_W-1:0] image_width;
  logic [THRESHOLD_W-1:0]   distance_threshold;
  logic [DIST_W-1:0]        limit_sq;
  logic                     cfg_write;
  reg_index_t               cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width        <= IMAGE_WIDTH_RST;
      distance_threshold <= THRESHOLD_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:        image_width        <= pwdata[IMAGE_WIDTH_W-1:0];
        REG_DISTANCE_THRESHOLD: distance_threshold <= pwdata[THRESHOLD_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_IMAGE_WIDTH:        prdata = APB_DATA_W'(image_width);
      REG_DISTANCE_THRESHOLD: prdata = APB_DATA_W'(distance_threshold);
    endcase
  end

  // Threshold squared, registered; the user must make config changes only while idle (not enforced)
  always_ff @(posedge clk) begin
    limit_sq <= DIST_W'(distance_threshold) * DIST_W'(distance_threshold);
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake: stage 1 (line read), stage 2 (histogram read),
  // result register
  // --------------------------------------------------------------------------
  logic s1_v, s2_v, res_v;
  logic res_free, s2_adv, s2_free, s1_adv, s1_free, accept;

  assign res_free      = !res_v || result_ready;
  assign s2_adv        = s2_v && res_free;
  assign s2_free       = !s2_v || res_free;
  assign s1_adv        = s1_v && s2_free;
  assign s1_free       = !s1_v || s2_free;
  assign request_ready = s1_free;
  assign accept        = request_valid && request_ready;
  assign result_valid  = res_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      res_v <= 1'b0;
    end else begin
      if (accept) begin
        s1_v <= 1'b1;
      end else if (s1_adv) begin
        s1_v <= 1'b0;
      end
      if (s1_adv) begin
        s2_v <= 1'b1;
      end else if (s2_adv) begin
        s2_v <= 1'b0;
      end
      if (s2_adv) begin
        res_v <= 1'b1;
      end else if (result_ready) begin
        res_v <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: raster position tracking
  // --------------------------------------------------------------------------
  logic [CW-1:0] col_pos, c_cur, col_pos_next;
  logic [1:0]    row_pos, row_cur, row_pos_next;
  logic [EW-1:0] eff_width;
  logic          is_push, wrap, classify_cur;
  pixel_t        in_pix;

  assign is_push = (request.action == ACT_PUSH);
  assign in_pix  = '{red: request.red, green: request.green, blue: request.blue};

  // Clamp the row length to [3, MAX_WIDTH]
  always_comb begin
    eff_width = EW'(image_width);
    if (image_width < MIN_IMAGE_WIDTH) begin
      eff_width = EW'(MIN_IMAGE_WIDTH);
    end else if (eff_width > EW'(MAX_WIDTH)) begin
      eff_width = EW'(MAX_WIDTH);
    end
  end

  always_comb begin
    c_cur        = request.start_of_frame ? '0 : col_pos;
    row_cur      = request.start_of_frame ? '0 : row_pos;
    classify_cur = (row_cur == 2'd2) && (c_cur >= CW'(2));
    wrap         = (EW'(c_cur) + EW'(1)) >= eff_width;
    if (wrap) begin
      col_pos_next = '0;
      row_pos_next = (row_cur == 2'd2) ? row_cur : row_cur + 2'd1;
    end else begin
      col_pos_next = c_cur + CW'(1);
      row_pos_next = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (accept && is_push) begin
      col_pos <= col_pos_next;
      row_pos <= row_pos_next;
    end
  end

  // Stage 1 registers
  action_t          s1_act;
  pixel_t           s1_pix;
  logic [CW-1:0]    s1_c;
  logic             s1_cls;
  logic [BIN_W-1:0] s1_bin;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_act <= request.action;
      s1_pix <= in_pix;
      s1_c   <= c_cur;
      s1_cls <= classify_cur && is_push;
      s1_bin <= request.bin_index;
    end
  end

  // --------------------------------------------------------------------------
  // Line stores: read at accept, written when the pixel leaves stage 1
  // --------------------------------------------------------------------------
  pixel_t older_mem [MAX_WIDTH];
  pixel_t prev_mem  [MAX_WIDTH];
  pixel_t older_rd, prev_rd;
  pixel_t col_top, col_mid;
  logic   s1_push, s1_wr;
  logic   lfwd_hit;
  pixel_t lfwd_older, lfwd_prev;

  assign s1_push = (s1_act == ACT_PUSH);
  assign s1_wr   = s1_adv && s1_push;

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      older_mem[s1_c] <= col_mid;
      prev_mem[s1_c]  <= s1_pix;
    end
    if (accept && is_push) begin
      older_rd <= older_mem[c_cur];
      prev_rd  <= prev_mem[c_cur];
    end
  end

  // Forward the write that lands on the same edge as this read
  always_ff @(posedge clk) begin
    if (accept && is_push) begin
      lfwd_hit   <= s1_wr && (s1_c == c_cur);
      lfwd_older <= col_mid;
      lfwd_prev  <= s1_pix;
    end
  end

  assign col_top = lfwd_hit ? lfwd_older : older_rd;
  assign col_mid = lfwd_hit ? lfwd_prev  : prev_rd;

  // --------------------------------------------------------------------------
  // Stage 1: 3x3 window and neighbor distances
  // --------------------------------------------------------------------------
  pixel_t            wcol [WIN_COLS];
  pixel_t            win  [9];
  pixel_t            centre;
  logic [DIST_W-1:0] nb_dist [NEIGHBORS];
  logic              s1_hist_op;
  logic [HBW-1:0]    s1_haddr;

  always_comb begin
    for (int k = 0; k < WIN_COLS; k++) begin
      win[k] = wcol[k];
    end
    win[6] = col_top;
    win[7] = col_mid;
    win[8] = s1_pix;
  end

  assign centre = wcol[4];

  // Neighbors are every window slot except the centre
  always_comb begin
    for (int j = 0; j < NEIGHBORS / 2; j++) begin
      nb_dist[j]                 = bic_sq_dist(centre, win[j]);
      nb_dist[j + NEIGHBORS / 2] = bic_sq_dist(centre, win[j + NEIGHBORS / 2 + 1]);
    end
  end

  // Shift the window by one column per push
  always_ff @(posedge clk) begin
    if (s1_wr) begin
      wcol[0] <= wcol[3];
      wcol[1] <= wcol[4];
      wcol[2] <= wcol[5];
      wcol[3] <= col_top;
      wcol[4] <= col_mid;
      wcol[5] <= s1_pix;
    end
  end

  assign s1_hist_op = (s1_act == ACT_READ_CLEAR) || s1_cls;
  assign s1_haddr   = (s1_act == ACT_READ_CLEAR) ? HBW'(s1_bin) : HBW'(centre.blue);

  // Stage 2 registers
  action_t           s2_act;
  logic              s2_cls;
  pixel_t            s2_centre;
  logic [DIST_W-1:0] s2_dist [NEIGHBORS];
  logic [HBW-1:0]    s2_haddr;
  logic              s2_hist_op;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_act    <= s1_act;
      s2_cls    <= s1_cls;
      s2_centre <= centre;
      s2_dist   <= nb_dist;
      s2_haddr  <= s1_haddr;
    end
  end

  assign s2_hist_op = (s2_act == ACT_READ_CLEAR) || s2_cls;

  // --------------------------------------------------------------------------
  // Histograms: one memory holding {border, interior} per bin, with a valid
  // bit per bin so reset empties every bin at once
  // --------------------------------------------------------------------------
  logic [HW-1:0]        hist_mem [HIST_BINS];
  logic [HIST_BINS-1:0] hist_vld;
  logic [HW-1:0]        hist_rd, hist_cur, hist_next, hfwd_data;
  logic                 hist_rd_ok, hfwd_hit, hist_wr, border;
  logic [COUNT_BITS-1:0] cnt_border, cnt_interior;

  assign hist_wr = s2_adv && s2_hist_op;

  always_ff @(posedge clk) begin
    if (hist_wr) begin
      hist_mem[s2_haddr] <= hist_next;
    end
    if (s1_adv && s1_hist_op) begin
      hist_rd <= hist_mem[s1_haddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_vld <= '0;
    end else if (hist_wr) begin
      hist_vld[s2_haddr] <= 1'b1;
    end
  end

  // Capture the valid bit with the read, and forward a same-edge write
  always_ff @(posedge clk) begin
    if (s1_adv && s1_hist_op) begin
      hist_rd_ok <= hist_vld[s1_haddr];
      hfwd_hit   <= hist_wr && (s2_haddr == s1_haddr);
      hfwd_data  <= hist_next;
    end
  end

  always_comb begin
    if (hfwd_hit) begin
      hist_cur = hfwd_data;
    end else if (hist_rd_ok) begin
      hist_cur = hist_rd;
    end else begin
      hist_cur = '0;
    end
  end

  assign cnt_border   = hist_cur[HW-1:COUNT_BITS];
  assign cnt_interior = hist_cur[COUNT_BITS-1:0];

  always_comb begin
    border = 1'b0;
    for (int j = 0; j < NEIGHBORS; j++) begin
      if (s2_dist[j] > limit_sq) begin
        border = 1'b1;
      end
    end
  end

  // Bump the matching bin, saturating; read-and-clear drops both counts
  always_comb begin
    hist_next = hist_cur;
    if (s2_act == ACT_READ_CLEAR) begin
      hist_next = '0;
    end else if (border) begin
      if (cnt_border != COUNT_MAX) begin
        hist_next[HW-1:COUNT_BITS] = cnt_border + COUNT_BITS'(1);
      end
    end else begin
      if (cnt_interior != COUNT_MAX) begin
        hist_next[COUNT_BITS-1:0] = cnt_interior + COUNT_BITS'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  result_t res_next;

  always_comb begin
    res_next = '0;
    if (s2_act == ACT_READ_CLEAR) begin
      res_next.bin_valid      = 1'b1;
      res_next.border_count   = OUT_COUNT_W'(cnt_border);
      res_next.interior_count = OUT_COUNT_W'(cnt_interior);
    end else if (s2_cls) begin
      res_next.centre_valid = 1'b1;
      res_next.is_border    = border;
      res_next.centre_blue  = s2_centre.blue;
      res_next.centre_green = s2_centre.green;
      res_next.centre_red   = s2_centre.red;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      result <= res_next;
    end
  end

endmodule

>>> rtl/core/bic_checker.sv
// ============================================================================
// bic_checker
// Port-level checks for the border/interior pixel classifier.
// ============================================================================
module bic_checker
  import bic_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  request_valid,
  input logic                  request_ready,
  input request_t              request,
  input logic                  result_valid,
  input logic                  result_ready,
  input result_t               result,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [APB_ADDR_W-1:0] paddr,
  input logic [APB_DATA_W-1:0] pwdata,
  input logic [APB_DATA_W-1:0] prdata,
  input logic                  pready
);

  logic req_acc;
  logic width_wr;

  assign req_acc  = request_valid && request_ready;
  assign width_wr = psel && penable && pwrite && pready && (paddr[2] == REG_IMAGE_WIDTH);

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid && request_ready)
    else $error("pipeline not empty after reset");

  // With the receiver taking results, a request surfaces at the result port
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (req_acc ##1 result_ready ##1 result_ready) |=> result_valid)
    else $error("result missing three cycles after request");

  // A row-length write reads back on the next cycle
  a_width_readback: assert property (@(posedge clk) disable iff (rst)
    ($past(width_wr) && $past(!rst) && psel && !pwrite && (paddr[2] == REG_IMAGE_WIDTH))
      |-> prdata == APB_DATA_W'($past(pwdata[IMAGE_WIDTH_W-1:0])))
    else $error("image width readback mismatch");

endmodule

bind border_interior_pixel_classifier_top bic_checker u_bic_checker (.*);

>>> tb/bic_classification_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bic_classification_checker
// Tracks configuration writes and accepted requests on the classifier ports,
// predicts the result of each request and compares it with the returned one.
// ----------------------------------------------------------------------------
module bic_classification_checker
  import bic_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  request_valid,
  input  logic                  request_ready,
  input  request_t              request,
  input  logic                  result_valid,
  input  logic                  result_ready,
  input  result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    mismatch_count,
  output int                    pending_results
);

  logic [IMAGE_WIDTH_W-1:0] image_width;
  logic [THRESHOLD_W-1:0]   distance_threshold;
  pixel_t                   line_above     [MAX_WIDTH];
  pixel_t                   line_two_above [MAX_WIDTH];
  pixel_t                   window_cols    [WIN_COLS];
  int                       column_pos;
  int                       row_pos;
  logic [OUT_COUNT_W-1:0]   border_hist    [DEF_HIST_BINS];
  logic [OUT_COUNT_W-1:0]   interior_hist  [DEF_HIST_BINS];
  result_t                  awaited_results [$];
  result_t                  predicted;
  result_t                  oldest;
  int                       failures;

  // One-sided squared color distance: only channels where the centre is larger
  function automatic int excess_distance(input pixel_t ctr, input pixel_t nb);
    int sum;
    int d;
    sum = 0;
    d = (ctr.blue > nb.blue) ? int'(ctr.blue) - int'(nb.blue) : 0;
    sum += d * d;
    d = (ctr.green > nb.green) ? int'(ctr.green) - int'(nb.green) : 0;
    sum += d * d;
    d = (ctr.red > nb.red) ? int'(ctr.red) - int'(nb.red) : 0;
    sum += d * d;
    return sum;
  endfunction

  function automatic string describe(input result_t r);
    return $sformatf("centre %0b border %0b bgr %02h %02h %02h bin %0b counts %0d %0d",
                     r.centre_valid, r.is_border, r.centre_blue, r.centre_green,
                     r.centre_red, r.bin_valid, r.border_count, r.interior_count);
  endfunction

  task automatic predict_result(input request_t req, output result_t res);
    pixel_t column [3];
    pixel_t nbr [9];
    pixel_t ctr;
    int     width;
    int     col;
    int     limit;
    int     k;
    logic   border;
    res = '0;
    if (req.action == ACT_READ_CLEAR) begin
      res.bin_valid      = 1'b1;
      res.border_count   = border_hist[req.bin_index];
      res.interior_count = interior_hist[req.bin_index];
      border_hist[req.bin_index]   = '0;
      interior_hist[req.bin_index] = '0;
    end else begin
      if (req.start_of_frame) begin
        column_pos = 0;
        row_pos    = 0;
      end
      width = int'(image_width);
      if (width < 3) width = 3;
      if (width > MAX_WIDTH) width = MAX_WIDTH;
      col = column_pos;
      column[0] = line_two_above[col];
      column[1] = line_above[col];
      column[2] = {req.red, req.green, req.blue};
      if (row_pos >= 2 && col >= 2) begin
        for (k = 0; k < 3; k++) begin
          nbr[k]     = window_cols[k];
          nbr[3 + k] = window_cols[3 + k];
          nbr[6 + k] = column[k];
        end
        ctr    = nbr[4];
        limit  = int'(distance_threshold) * int'(distance_threshold);
        border = 1'b0;
        for (k = 0; k < 9; k++) begin
          if (k != 4 && excess_distance(ctr, nbr[k]) > limit) border = 1'b1;
        end
        // Bins saturate at all ones
        if (border) begin
          if (border_hist[ctr.blue] != '1) border_hist[ctr.blue] += 1'b1;
        end else begin
          if (interior_hist[ctr.blue] != '1) interior_hist[ctr.blue] += 1'b1;
        end
        res.centre_valid = 1'b1;
        res.is_border    = border;
        res.centre_blue  = ctr.blue;
        res.centre_green = ctr.green;
        res.centre_red   = ctr.red;
      end
      for (k = 0; k < 3; k++) begin
        window_cols[k]     = window_cols[3 + k];
        window_cols[3 + k] = column[k];
      end
      line_two_above[col] = column[1];
      line_above[col]     = column[2];
      if (col + 1 >= width) begin
        column_pos = 0;
        if (row_pos < 2) row_pos++;
      end else begin
        column_pos = col + 1;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      image_width        = IMAGE_WIDTH_RST;
      distance_threshold = THRESHOLD_RST;
      column_pos         = 0;
      row_pos            = 0;
      for (int i = 0; i < WIN_COLS; i++) window_cols[i] = '0;
      for (int i = 0; i < DEF_HIST_BINS; i++) begin
        border_hist[i]   = '0;
        interior_hist[i] = '0;
      end
      awaited_results.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (awaited_results.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: result with none pending: %s", $time, describe(result));
        end else begin
          oldest = awaited_results.pop_front();
          if (result.centre_valid   !== oldest.centre_valid   ||
              result.is_border      !== oldest.is_border      ||
              result.centre_blue    !== oldest.centre_blue    ||
              result.centre_green   !== oldest.centre_green   ||
              result.centre_red     !== oldest.centre_red     ||
              result.bin_valid      !== oldest.bin_valid      ||
              result.border_count   !== oldest.border_count   ||
              result.interior_count !== oldest.interior_count) begin
            failures++;
            if (failures <= 10) begin
              $display("%0t: result mismatch", $time);
              $display("  expected %s", describe(oldest));
              $display("  actual   %s", describe(result));
            end
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        case (reg_index_t'(paddr[APB_ADDR_W-1:2]))
          REG_IMAGE_WIDTH:        image_width        = pwdata[IMAGE_WIDTH_W-1:0];
          REG_DISTANCE_THRESHOLD: distance_threshold = pwdata[THRESHOLD_W-1:0];
          default: ;
        endcase
      end
      if (request_valid && request_ready) begin
        predict_result(request, predicted);
        awaited_results.push_back(predicted);
      end
    end
    mismatch_count  <= failures;
    pending_results <= awaited_results.size();
  end

endmodule

>>> tb/border_interior_pixel_classifier_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// border_interior_pixel_classifier_top_test
// Drives pixel frames and histogram read-and-clear requests into the
// classifier under changing image widths and distance thresholds, with random
// gaps on the request side and random stalls on the result side. A checker
// beside the block predicts every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module border_interior_pixel_classifier_top_test;
  import bic_pkg::*;

  localparam int IDLE_LIMIT  = 2000;  // cycles with no transfer of any kind
  localparam int ITEM_TARGET = 450;   // requests sent by the frame streams

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  request_valid = 1'b0;
  logic                  request_ready;
  request_t              request       = '0;
  logic                  result_valid;
  logic                  result_ready  = 1'b1;
  result_t               result;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int         mismatch_count;
  int         pending_results;
  int         quiet_cycles = 0;
  int         ready_run    = 0;
  int         frame_width  = 640;  // effective width the frames are built for
  int         random_items = 0;
  bit         no_gaps      = 1'b0;
  bit         need_sof     = 1'b1; // set after widening: next push must open a frame
  logic [7:0] recent_blue  = '0;

  border_interior_pixel_classifier_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_ready (request_ready),
    .request       (request),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  bic_classification_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .request_valid   (request_valid),
    .request_ready   (request_ready),
    .request         (request),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .result          (result),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result-side stalls: mostly short, a few long, and long ready stretches
  function automatic int stall_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return $urandom_range(3, 1);
    if (roll < 95) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic int ready_length();
    if ($urandom_range(4) == 0) return $urandom_range(200, 50);
    return $urandom_range(20, 1);
  endfunction

  always @(posedge clk) begin
    if (ready_run > 0) begin
      ready_run <= ready_run - 1;
    end else if (result_ready) begin
      result_ready <= 1'b0;
      ready_run    <= stall_length();
    end else begin
      result_ready <= 1'b1;
      ready_run    <= ready_length();
    end
  end

  // Watchdog: count cycles in which nothing moves on any port
  always @(posedge clk) begin
    if (rst || (request_valid && request_ready) || (result_valid && result_ready) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // Request-side gaps; a frame may run with none at all
  function automatic int request_gap();
    int roll;
    roll = $urandom_range(99);
    if (no_gaps || roll < 55) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  // Present one request and hold it until the block takes it. Valid stays
  // high afterwards so back-to-back requests leave no gap on the port.
  task automatic send(input request_t req);
    int gap;
    gap = request_gap();
    if (gap > 0) begin
      request_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request_valid <= 1'b1;
    request       <= req;
    do begin
      @(posedge clk);
    end while (!request_ready);
  endtask

  task automatic push_pixel(input pixel_t px, input logic sof);
    request_t req;
    req.action         = ACT_PUSH;
    req.start_of_frame = sof;
    req.blue           = px.blue;
    req.green          = px.green;
    req.red            = px.red;
    req.bin_index      = 8'($urandom);  // ignored on a push
    recent_blue        = px.blue;
    if (sof) need_sof  = 1'b0;
    send(req);
  endtask

  // Read and clear one bin; the pixel fields and the frame flag ride along as junk
  task automatic read_bin(input logic [7:0] bin);
    request_t req;
    req.action         = ACT_READ_CLEAR;
    req.start_of_frame = 1'($urandom);
    req.blue           = 8'($urandom);
    req.green          = 8'($urandom);
    req.red            = 8'($urandom);
    req.bin_index      = bin;
    send(req);
  endtask

  // Drop valid, then wait until every outstanding request has returned
  // its result, and give the pipeline time to settle.
  task automatic wait_for_results();
    request_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_results != 0);
    repeat (4) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the
  // access edge. Then drop psel and idle so back-to-back writes never collide.
  task automatic write_register(input reg_index_t idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Write the width and/or the threshold (a negative value skips one) while idle.
  // Unused upper data bits carry junk; the registers must ignore them.
  task automatic configure(input int width, input int threshold);
    int eff;
    wait_for_results();
    if (width >= 0) begin
      write_register(REG_IMAGE_WIDTH,
                     {20'($urandom), IMAGE_WIDTH_W'(width)});
      eff = width;
      if (eff < 3) eff = 3;
      if (eff > DEF_MAX_WIDTH) eff = DEF_MAX_WIDTH;
      // Widening mid-frame would read line store entries never written
      if (eff > frame_width) need_sof = 1'b1;
      frame_width = eff;
    end
    if (threshold >= 0)
      write_register(REG_DISTANCE_THRESHOLD,
                     {23'($urandom), THRESHOLD_W'(threshold)});
  endtask

  function automatic logic [7:0] jitter(input logic [7:0] base, input int spread);
    int v;
    v = int'(base) + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // Spread 0 gives flat areas (interior), large spreads give busy texture
  function automatic pixel_t scene_pixel(input pixel_t base, input int spread);
    pixel_t px;
    if (spread >= 255) return pixel_t'($urandom);
    px.blue  = jitter(base.blue, spread);
    px.green = jitter(base.green, spread);
    px.red   = jitter(base.red, spread);
    return px;
  endfunction

  function automatic int pick_spread();
    case ($urandom_range(5))
      0:       return 0;
      1:       return 2;
      2:       return 6;
      3:       return 15;
      4:       return 40;
      default: return 255;
    endcase
  endfunction

  // Stream rows of one frame; cut_at > 0 truncates it. Reads of recent bins
  // are mixed in, stray start-of-frame flags break a few frames, and now
  // and then the sender holds until all results are back.
  task automatic stream_frame(input int rows, input bit with_sof, input int cut_at);
    pixel_t base;
    int     spread;
    int     total;
    int     n;
    base    = pixel_t'($urandom);
    spread  = pick_spread();
    no_gaps = ($urandom_range(3) == 0);
    total   = rows * frame_width;
    if (cut_at > 0 && cut_at < total) total = cut_at;
    for (n = 0; n < total; n++) begin
      push_pixel(scene_pixel(base, spread),
                 (n == 0 && (with_sof || need_sof)) || $urandom_range(199) == 0);
      random_items++;
      if ($urandom_range(9) == 0) begin
        read_bin($urandom_range(1) ? recent_blue : 8'($urandom));
        random_items++;
      end
      if ($urandom_range(299) == 0) wait_for_results();
    end
  endtask

  initial begin
    int width;
    int threshold;
    int roll;
    int frames;
    int rows;
    int cut;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: 3-wide frames so every row past the second classifies
    configure(3, -1);
    read_bin(8'h00);                    // empty bin reads zero
    push_pixel(24'h000000, 1'b1);       // frame opens here
    push_pixel(24'h0000FF, 1'b0);
    push_pixel(24'h00FF00, 1'b0);
    push_pixel(24'hFF0000, 1'b0);
    push_pixel(24'hFFFFFF, 1'b0);       // centre: white against black -> border
    push_pixel(24'h808080, 1'b0);
    read_bin(8'hFF);                    // read between pushes leaves the window alone
    push_pixel(24'h7F7F7F, 1'b0);       // edge columns give zero results
    push_pixel(24'hFEFEFE, 1'b0);
    push_pixel(24'h010203, 1'b0);       // classifies the white centre
    // No new frame: rows keep counting, one tall frame
    push_pixel(24'hFFFFFF, 1'b0);
    push_pixel(24'h000000, 1'b0);
    push_pixel(24'hFFFFFF, 1'b0);
    // Flat frame: every neighbor equal -> interior
    for (int i = 0; i < 9; i++) push_pixel(24'h808080, i == 0);
    read_bin(8'h80);
    read_bin(8'hFF);

    // Clamped widest image: a short run that stays inside the first row
    configure(4095, 442);
    stream_frame(3, 1'b1, 40);
    configure(0, 511);                  // width below minimum acts as three
    stream_frame(4, 1'b1, 0);

    // Random phases, each with its own width and threshold
    while (random_items < ITEM_TARGET) begin
      roll = $urandom_range(99);
      if (roll < 10) width = $urandom_range(2);
      else if (roll < 80) width = $urandom_range(8, 3);
      else if (roll < 95) width = $urandom_range(24, 9);
      else width = $urandom_range(64, 25);
      roll = $urandom_range(99);
      if (roll < 15) threshold = 0;
      else if (roll < 25) threshold = 442;
      else if (roll < 35) threshold = 511;
      else if (roll < 50) threshold = 30;
      else threshold = $urandom_range(120);
      case ($urandom_range(3))
        0:       configure(width, -1);
        1:       configure(-1, threshold);
        default: configure(width, threshold);
      endcase
      frames = $urandom_range(3, 1);
      repeat (frames) begin
        rows = $urandom_range(5, 3);
        cut  = ($urandom_range(9) == 0) ? $urandom_range(rows * frame_width, 1) : 0;
        stream_frame(rows, $urandom_range(5) != 0, cut);
      end
    end

    // Drain everything, give the block time to show any stray result
    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> border_interior_pixel_classifier_top.f
rtl/core/bic_pkg.sv
rtl/core/border_interior_pixel_classifier_top.sv
rtl/core/bic_checker.sv
tb/bic_classification_checker.sv
tb/border_interior_pixel_classifier_top_test.sv
